### hw/rtl/aarm_pkg.sv
package aarm_pkg;

    localparam int W = 32;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z = 8'd3;

    localparam logic signed [W-1:0] AXIS_Z_RESET = 32'sd65536;

    // Angle scale into 2^-32 turn units, and pi in Q30.
    localparam logic signed [33:0] TURN_K = 34'sd683565276;
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    typedef struct packed {
        logic signed [W-1:0] c0;
        logic signed [W-1:0] c1;
        logic signed [W-1:0] c2;
        logic signed [W-1:0] c3;
    } t_row;

    // Rotation entries, row-major by rotation column k then element j.
    typedef struct packed {
        logic              zero;
        logic [8:0][W-1:0] rot;
    } t_coef;

    // Divisors of the sin series followed by those of the cos series.
    function automatic logic [6:0] ser_k(input logic [3:0] idx);
        logic [6:0] k;
        case (idx)
            4'd0:    k = 7'd72;
            4'd1:    k = 7'd42;
            4'd2:    k = 7'd20;
            4'd3:    k = 7'd6;
            4'd4:    k = 7'd90;
            4'd5:    k = 7'd56;
            4'd6:    k = 7'd30;
            4'd7:    k = 7'd12;
            default: k = 7'd2;
        endcase
        return k;
    endfunction

    // Reciprocals of the series divisors, each ceil(2^s / k) with
    // s = 30 + ceil(log2 k), so that (n * m) >> s equals n / k for n below 2^30.
    function automatic logic [30:0] ser_m(input logic [3:0] idx);
        logic [30:0] m;
        case (idx)
            4'd0:    m = 31'd1908874354;
            4'd1:    m = 31'd1636178018;
            4'd2:    m = 31'd1717986919;
            4'd3:    m = 31'd1431655766;
            4'd4:    m = 31'd1527099484;
            4'd5:    m = 31'd1227133514;
            4'd6:    m = 31'd1145324613;
            4'd7:    m = 31'd1431655766;
            default: m = 31'd1073741824;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/aarm_div.sv
module aarm_div
    import aarm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[63]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
            r_dvd <= {r_dvd[62:0], ge};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dvd;

endmodule

### hw/rtl/aarm_coef.sv
module aarm_coef
    import aarm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data,
    output logic                 o_busy,
    output t_coef                o_coef
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAG, ST_SHIFT, ST_SQ, ST_SQRT, ST_NDIV_GO, ST_NDIV_WAIT,
        ST_PH, ST_RED, ST_X2, ST_X2S, ST_SER_MUL, ST_SER_GO, ST_SER_WAIT,
        ST_SIN_MUL, ST_SIN_SAV, ST_MAP, ST_TM, ST_ENT
    } t_state;

    t_state r_state;

    logic signed [W-1:0] r_angle, r_ax, r_ay, r_az;
    logic [31:0]         r_mag [3];
    logic [31:0]         r_m;
    logic                r_zero;
    logic [63:0]         r_sum, r_num, r_res, r_bit;
    logic signed [31:0]  r_n [3];
    logic [2:0]          r_oct;
    logic [30:0]         r_x, r_x2, r_t, r_s0;
    logic signed [31:0]  r_s, r_c;
    logic signed [33:0]  r_tm [3];
    logic signed [33:0]  r_a;
    logic [8:0][W-1:0]   r_rot;
    logic [3:0]          r_idx;
    logic [3:0]          r_e;
    logic [1:0]          r_k, r_j, r_ph;
    logic signed [67:0]  r_prod;

    logic signed [33:0] mul_a, mul_b;
    logic               div_start, div_busy;
    logic [63:0]        div_dvd, div_q;
    logic [31:0]        div_dvs;

    logic [31:0] abs_v [3];
    logic [31:0] abs_max;
    logic [2:0]  axis_neg;
    logic [63:0] sq_rb;
    logic [28:0] ph_f;
    logic [29:0] ph_r;
    logic        ent_diag, ent_plus;
    logic [1:0]  ent_l;
    logic signed [37:0] tr_prod;
    logic signed [38:0] ent_sum;
    logic signed [31:0] s0_s, c0_s, q_s;
    logic [29:0] ser_q;

    // Q30 product scaled back, truncated toward zero.
    function automatic logic signed [37:0] mq_trunc(input logic signed [67:0] p);
        logic signed [67:0] adj;
        adj = p + (p[67] ? 68'sd1073741823 : 68'sd0);
        return $signed(adj[67:30]);
    endfunction

    always_comb begin
        axis_neg = {r_az[W-1], r_ay[W-1], r_ax[W-1]};
        abs_v[0] = r_ax[W-1] ? 32'(-r_ax) : 32'(r_ax);
        abs_v[1] = r_ay[W-1] ? 32'(-r_ay) : 32'(r_ay);
        abs_v[2] = r_az[W-1] ? 32'(-r_az) : 32'(r_az);
        abs_max  = abs_v[0];
        if (abs_v[1] > abs_max) abs_max = abs_v[1];
        if (abs_v[2] > abs_max) abs_max = abs_v[2];

        sq_rb = r_res + r_bit;
        ph_f  = r_prod[44:16];
        ph_r  = r_prod[45] ? (30'h2000_0000 - {1'b0, ph_f}) : {1'b0, ph_f};

        ent_diag = r_k == r_j;
        ent_plus = r_j == ((r_k == 2'd2) ? 2'd0 : r_k + 2'd1);
        ent_l    = ent_diag ? 2'd0 : 2'd3 - r_k - r_j;
        tr_prod  = mq_trunc(r_prod);
        if (ent_diag) begin
            ent_sum = 39'(r_c) + 39'(r_a);
        end else if (ent_plus) begin
            ent_sum = 39'(r_a) + 39'(tr_prod);
        end else begin
            ent_sum = 39'(r_a) - 39'(tr_prod);
        end

        s0_s = $signed({1'b0, r_s0});
        c0_s = $signed({1'b0, r_t});
        q_s  = $signed(div_q[31:0]);

        // Series quotient: the reciprocal product shifted by that divisor's scale.
        case (r_idx) inside
            4'd0, 4'd4: ser_q = r_prod[66:37];
            4'd1, 4'd5: ser_q = r_prod[65:36];
            4'd2, 4'd6: ser_q = r_prod[64:35];
            4'd3:       ser_q = r_prod[62:33];
            4'd7:       ser_q = r_prod[63:34];
            default:    ser_q = r_prod[60:31];
        endcase

        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (r_state)
            ST_SQ: begin
                if (r_idx[1:0] != 2'd3) begin
                    mul_a = $signed({2'b0, r_mag[r_idx[1:0]]});
                    mul_b = $signed({2'b0, r_mag[r_idx[1:0]]});
                end
            end
            ST_NDIV_GO: begin
                div_start = 1'b1;
                div_dvd   = {2'b0, r_mag[r_idx[1:0]], 30'b0};
                div_dvs   = r_res[31:0];
            end
            ST_PH: begin
                mul_a = 34'(r_angle);
                mul_b = TURN_K;
            end
            ST_RED: begin
                mul_a = $signed({4'b0, ph_r});
                mul_b = PI_Q30;
            end
            ST_X2: begin
                mul_a = $signed({3'b0, r_prod[61:31]});
                mul_b = $signed({3'b0, r_prod[61:31]});
            end
            ST_SER_MUL: begin
                mul_a = $signed({3'b0, r_x2});
                mul_b = $signed({3'b0, r_t});
            end
            ST_SER_GO: begin
                mul_a = $signed({4'b0, r_prod[59:30]});
                mul_b = $signed({3'b0, ser_m(r_idx)});
            end
            ST_SIN_MUL: begin
                mul_a = $signed({3'b0, r_x});
                mul_b = $signed({3'b0, r_t});
            end
            ST_TM: begin
                if (r_idx[1:0] != 2'd3) begin
                    mul_a = $signed({3'b0, Q30_ONE}) - 34'(r_c);
                    mul_b = 34'(r_n[r_idx[1:0]]);
                end
            end
            ST_ENT: begin
                if (r_ph == 2'd0) begin
                    mul_a = r_tm[r_k];
                    mul_b = 34'(r_n[r_j]);
                end else if (r_ph == 2'd1) begin
                    mul_a = 34'(r_s);
                    mul_b = 34'(r_n[ent_l]);
                end
            end
            default: ;
        endcase
    end

    aarm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= ST_MAG;
            r_angle <= '0;
            r_ax    <= '0;
            r_ay    <= '0;
            r_az    <= AXIS_Z_RESET;
            r_zero  <= 1'b0;
        end else if (i_cfg_we) begin
            // Any write restarts the coefficient computation.
            r_state <= ST_MAG;
            case (i_cfg_idx)
                CFG_ANGLE:  r_angle <= i_cfg_data;
                CFG_AXIS_X: r_ax    <= i_cfg_data;
                CFG_AXIS_Y: r_ay    <= i_cfg_data;
                CFG_AXIS_Z: r_az    <= i_cfg_data;
                default: ;
            endcase
        end else begin
            unique case (r_state)
                ST_IDLE: ;
                ST_MAG: begin
                    r_mag[0] <= abs_v[0];
                    r_mag[1] <= abs_v[1];
                    r_mag[2] <= abs_v[2];
                    r_m      <= abs_max;
                    r_zero   <= abs_max == 32'd0;
                    r_state  <= (abs_max == 32'd0) ? ST_IDLE : ST_SHIFT;
                    r_idx    <= '0;
                end
                ST_SHIFT: begin
                    if (r_m[31:30] == 2'b00) begin
                        r_m      <= {r_m[30:0], 1'b0};
                        r_mag[0] <= {r_mag[0][30:0], 1'b0};
                        r_mag[1] <= {r_mag[1][30:0], 1'b0};
                        r_mag[2] <= {r_mag[2][30:0], 1'b0};
                    end else begin
                        r_state <= ST_SQ;
                        r_sum   <= '0;
                    end
                end
                ST_SQ: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_idx != 4'd0) r_sum <= r_sum + r_prod[63:0];
                    if (r_idx == 4'd3) begin
                        r_num   <= r_sum + r_prod[63:0];
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_num >= sq_rb) begin
                        r_num <= r_num - sq_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_idx   <= '0;
                        r_state <= ST_NDIV_GO;
                    end
                end
                ST_NDIV_GO: r_state <= ST_NDIV_WAIT;
                ST_NDIV_WAIT: begin
                    if (!div_busy) begin
                        r_n[r_idx[1:0]] <= axis_neg[r_idx[1:0]] ? -q_s : q_s;
                        r_idx   <= r_idx + 4'd1;
                        r_state <= (r_idx == 4'd2) ? ST_PH : ST_NDIV_GO;
                    end
                end
                ST_PH: r_state <= ST_RED;
                ST_RED: begin
                    r_oct   <= r_prod[47:45];
                    r_state <= ST_X2;
                end
                ST_X2: begin
                    r_x     <= r_prod[61:31];
                    r_state <= ST_X2S;
                end
                ST_X2S: begin
                    r_x2    <= r_prod[60:30];
                    r_t     <= Q30_ONE;
                    r_idx   <= '0;
                    r_state <= ST_SER_MUL;
                end
                ST_SER_MUL: r_state <= ST_SER_GO;
                ST_SER_GO:  r_state <= ST_SER_WAIT;
                ST_SER_WAIT: begin
                    r_t   <= Q30_ONE - {1'b0, ser_q};
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd3) begin
                        r_state <= ST_SIN_MUL;
                    end else if (r_idx == 4'd8) begin
                        r_state <= ST_MAP;
                    end else begin
                        r_state <= ST_SER_MUL;
                    end
                end
                ST_SIN_MUL: r_state <= ST_SIN_SAV;
                ST_SIN_SAV: begin
                    r_s0    <= r_prod[60:30];
                    r_t     <= Q30_ONE;
                    r_state <= ST_SER_MUL;
                end
                ST_MAP: begin
                    case (r_oct)
                        3'd0: begin r_s <= s0_s;  r_c <= c0_s;  end
                        3'd1: begin r_s <= c0_s;  r_c <= s0_s;  end
                        3'd2: begin r_s <= c0_s;  r_c <= -s0_s; end
                        3'd3: begin r_s <= s0_s;  r_c <= -c0_s; end
                        3'd4: begin r_s <= -s0_s; r_c <= -c0_s; end
                        3'd5: begin r_s <= -c0_s; r_c <= -s0_s; end
                        3'd6: begin r_s <= -c0_s; r_c <= s0_s;  end
                        default: begin r_s <= -s0_s; r_c <= c0_s; end
                    endcase
                    r_idx   <= '0;
                    r_state <= ST_TM;
                end
                ST_TM: begin
                    r_idx <= r_idx + 4'd1;
                    case (r_idx[1:0])
                        2'd1:    r_tm[0] <= tr_prod[33:0];
                        2'd2:    r_tm[1] <= tr_prod[33:0];
                        2'd3:    r_tm[2] <= tr_prod[33:0];
                        default: ;
                    endcase
                    if (r_idx[1:0] == 2'd3) begin
                        r_e     <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_ph    <= '0;
                        r_state <= ST_ENT;
                    end
                end
                ST_ENT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        r_a  <= tr_prod[33:0];
                        r_ph <= 2'd2;
                    end else begin
                        if (ent_sum > 39'sd1073741824) begin
                            r_rot[r_e] <= 32'h4000_0000;
                        end else if (ent_sum < -39'sd1073741824) begin
                            r_rot[r_e] <= 32'hC000_0000;
                        end else begin
                            r_rot[r_e] <= ent_sum[31:0];
                        end
                        r_ph <= 2'd0;
                        r_e  <= r_e + 4'd1;
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            r_k <= r_k + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                        if (r_e == 4'd8) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy      = r_state != ST_IDLE;
    assign o_coef.zero = r_zero;
    assign o_coef.rot  = r_rot;

endmodule

### hw/rtl/aarm_lane.sv
module aarm_lane
    import aarm_pkg::*;
(
    input  logic              i_clk,
    input  t_row              i_row,
    input  logic [2:0][W-1:0] i_rot,
    output logic signed [W-1:0] o_res
);

    logic signed [63:0] r_p [3];
    logic signed [65:0] r_sum;
    logic signed [65:0] adj;
    logic signed [35:0] q;

    always_comb begin
        adj = r_sum + (r_sum[65] ? 66'sd1073741823 : 66'sd0);
        q   = $signed(adj[65:30]);
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= i_row.c0 * $signed(i_rot[0]);
        r_p[1] <= i_row.c1 * $signed(i_rot[1]);
        r_p[2] <= i_row.c2 * $signed(i_rot[2]);
        r_sum  <= 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
        if (q > 36'sd2147483647) begin
            o_res <= 32'sh7FFF_FFFF;
        end else if (q < -36'sd2147483648) begin
            o_res <= 32'sh8000_0000;
        end else begin
            o_res <= q[31:0];
        end
    end

endmodule

### hw/rtl/axis_angle_rotate_matrix.sv
// Rotates one row of a 4x4 column-major transform per item by the configured
// axis-angle rotation (Q16.16 in and out). An item is taken on any cycle with
// start high and busy low, one per cycle sustained; its result passes through
// the lane product, lane sum, lane result and o_out registers and appears on
// the o_out ports with o_done high for one cycle; the receiver cannot stall.
// The three rotated entries come from three dot product lanes; column 3 passes
// through. After reset and after every configuration write busy stays high
// while a sequential engine with one shared multiplier and a bit-serial
// divider rebuilds the rotation, most of the rebuild going to the three
// axis divides. A zero axis sets o_zero_axis and returns the row unchanged.
module axis_angle_rotate_matrix
    import aarm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]         i_cfg_data,
    input  logic signed [W-1:0]  i_in_c0,
    input  logic signed [W-1:0]  i_in_c1,
    input  logic signed [W-1:0]  i_in_c2,
    input  logic signed [W-1:0]  i_in_c3,
    output logic signed [W-1:0]  o_out_c0,
    output logic signed [W-1:0]  o_out_c1,
    output logic signed [W-1:0]  o_out_c2,
    output logic signed [W-1:0]  o_out_c3,
    output logic                 o_zero_axis,
    output logic                 o_done
);

    t_coef              coef;
    t_row               in_row;
    t_row               r_raw [3];
    logic [3:0]         r_vld;
    logic signed [W-1:0] lane_res [3];

    assign in_row = '{c0: i_in_c0, c1: i_in_c1, c2: i_in_c2, c3: i_in_c3};

    aarm_coef u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (busy),
        .o_coef     (coef)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        aarm_lane u_lane (
            .i_clk (i_clk),
            .i_row (in_row),
            .i_rot (coef.rot[3*k +: 3]),
            .o_res (lane_res[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], start & ~busy};
        end
        r_raw[0] <= in_row;
        r_raw[1] <= r_raw[0];
        r_raw[2] <= r_raw[1];
        // Merge the lanes; a zero axis hands the row back unchanged.
        o_out_c0    <= coef.zero ? r_raw[2].c0 : lane_res[0];
        o_out_c1    <= coef.zero ? r_raw[2].c1 : lane_res[1];
        o_out_c2    <= coef.zero ? r_raw[2].c2 : lane_res[2];
        o_out_c3    <= r_raw[2].c3;
        o_zero_axis <= coef.zero;
    end

    assign o_done = r_vld[3];

endmodule
